/* sv/qau_pkg.sv */
// qau_pkg: shared types and constants of the quaternion arithmetic unit.
// Holds the request and response beat types and the action codes.
// Depends on nothing.
package qau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int NORM_GUARD = 14;

   localparam logic [1:0] ACT_PRODUCT   = 2'd0;
   localparam logic [1:0] ACT_ROTATE    = 2'd1;
   localparam logic [1:0] ACT_NORMALIZE = 2'd2;
   localparam logic [1:0] ACT_RESERVED  = 2'd3;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [DATA_WIDTH-1:0] a_w;
      logic signed [DATA_WIDTH-1:0] a_x;
      logic signed [DATA_WIDTH-1:0] a_y;
      logic signed [DATA_WIDTH-1:0] a_z;
      logic signed [DATA_WIDTH-1:0] b_w;
      logic signed [DATA_WIDTH-1:0] b_x;
      logic signed [DATA_WIDTH-1:0] b_y;
      logic signed [DATA_WIDTH-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] r_w;
      logic signed [DATA_WIDTH-1:0] r_x;
      logic signed [DATA_WIDTH-1:0] r_y;
      logic signed [DATA_WIDTH-1:0] r_z;
      logic                         zero_length;
   } rsp_type;

endpackage

/* sv/qau_isqrt.sv */
// qau_isqrt: pipelined integer square root, one root bit per register stage.
// Carries a side word alongside the root. Depends on nothing.
module qau_isqrt #(
   parameter int IN_W   = 62,
   parameter int SIDE_W = 64,
   localparam int R     = IN_W / 2
) (
   input  logic              clock,
   input  logic [IN_W-1:0]   in_n,
   input  logic [SIDE_W-1:0] in_side,
   output logic [R-1:0]      out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int RW = R + 3;

   typedef struct packed {
      logic [RW-1:0]     rem;
      logic [R-1:0]      root;
      logic [IN_W-1:0]   n;
      logic [SIDE_W-1:0] side;
   } sq_type;

   function automatic sq_type sq_step(input sq_type c);
      logic [RW-1:0] rs;
      logic [RW-1:0] trial;
      sq_type        o;
      o     = c;
      rs    = {c.rem[RW-3:0], c.n[IN_W-1 -: 2]};
      trial = RW'({c.root, 2'b01});
      if (rs >= trial) begin
         o.rem  = rs - trial;
         o.root = {c.root[R-2:0], 1'b1};
      end else begin
         o.rem  = rs;
         o.root = {c.root[R-2:0], 1'b0};
      end
      o.n = {c.n[IN_W-3:0], 2'b00};
      return o;
   endfunction

   sq_type stage_ff [R];
   sq_type stage_in [R];
   sq_type first;

   always_comb begin
      first.rem   = '0;
      first.root  = '0;
      first.n     = in_n;
      first.side  = in_side;
      stage_in[0] = sq_step(first);
      for (int s = 1; s < R; s++) begin
         stage_in[s] = sq_step(stage_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < R; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign out_root = stage_ff[R-1].root;
   assign out_side = stage_ff[R-1].side;

endmodule

/* sv/qau_div.sv */
// qau_div: pipelined restoring divider lane, one quotient bit per register stage.
// Expects the quotient to fit in QB bits. Depends on nothing.
module qau_div #(
   parameter int NUM_W = 45,
   parameter int DEN_W = 31,
   parameter int QB    = 15
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic [QB-1:0]    out_q
);

   localparam int CW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

   typedef struct packed {
      logic [CW-1:0]    rem;
      logic [DEN_W-1:0] den;
      logic [QB-1:0]    q;
   } dv_type;

   function automatic dv_type dv_step(input dv_type c, input int k);
      logic [CW-1:0] dsh;
      dv_type        o;
      o   = c;
      dsh = CW'(c.den) << k;
      if (c.rem >= dsh) begin
         o.rem = c.rem - dsh;
         o.q   = {c.q[QB-2:0], 1'b1};
      end else begin
         o.q   = {c.q[QB-2:0], 1'b0};
      end
      return o;
   endfunction

   dv_type stage_ff [QB];
   dv_type stage_in [QB];
   dv_type first;

   always_comb begin
      first.rem   = CW'(in_num);
      first.den   = in_den;
      first.q     = '0;
      stage_in[0] = dv_step(first, QB - 1);
      for (int s = 1; s < QB; s++) begin
         stage_in[s] = dv_step(stage_ff[s-1], QB - 1 - s);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QB; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign out_q = stage_ff[QB-1].q;

endmodule

/* sv/quaternion_arith_unit.sv */
// quaternion_arith_unit: pipelined Q2.14 quaternion product, vector rotate and normalize.
// Uses qau_pkg types, qau_isqrt for the length and four qau_div lanes.
//
//   channel   ports                     per beat
//   request   start, busy, req_data     action, quaternion A, operand B
//   response  rsp_valid, rsp_data       result quaternion or vector, zero_length
//
// One beat enters every cycle; busy is high only during reset.
// The delay is set by R = ceil((2*16 + 1 + 2*14) / 2) = 31 root steps and by
// FRAC_BITS + 1 divide steps in the root and divide chains.
// Every action takes the same latency, so responses leave in request order.
// Reset clears the valid bits only; the receiver takes each response beat as it comes.
module quaternion_arith_unit #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qau_pkg::req_type  req_data,
   output logic              rsp_valid,
   output qau_pkg::rsp_type  rsp_data
);

   localparam int DW    = qau_pkg::DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int NG    = qau_pkg::NORM_GUARD;
   localparam int PW    = 2 * DW;
   localparam int SW    = PW + 2;
   localparam int MW    = ((PW > 2 * F) ? PW : 2 * F) + 4;
   localparam int MRW   = MW - F;
   localparam int TW    = MRW + DW;
   localparam int FW    = TW + 2;
   localparam int QB    = F + 1;
   localparam int XW0   = (SW > FW) ? SW : FW;
   localparam int XW    = (XW0 > QB + 2) ? XW0 : QB + 2;
   localparam int DSW   = PW + 1;
   localparam int NW0   = DSW + 2 * NG;
   localparam int R     = (NW0 + 1) / 2;
   localparam int NW    = 2 * R;
   localparam int NUM_W = DW + F + NG + 1;
   localparam int DLY   = R + QB - 2;
   localparam int LAT   = R + QB + 3;
   localparam int SMAXI = 2 ** (DW - 1) - 1;
   localparam int SMINI = -(2 ** (DW - 1));
   localparam logic signed [DW-1:0] R_ONE =
      (F > DW - 2) ? {1'b0, {(DW-1){1'b1}}} : DW'(64'd1 << F);

   typedef struct packed {
      logic [1:0]           act;
      logic                 zero;
      logic [3:0]           neg;
      logic signed [DW-1:0] r_w;
      logic signed [DW-1:0] r_x;
      logic signed [DW-1:0] r_y;
      logic signed [DW-1:0] r_z;
   } meta_type;

   function automatic logic signed [XW-1:0] rnd_x(input logic signed [XW-1:0] v);
      return (v + (XW'(1) <<< (F - 1))) >>> F;
   endfunction

   function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] t;
      t = v;
      if (t > XW'(SMAXI)) begin
         t = XW'(SMAXI);
      end else if (t < XW'(SMINI)) begin
         t = XW'(SMINI);
      end
      return t[DW-1:0];
   endfunction

   // stage 1: products, component magnitudes and signs, zero test
   logic signed [DW-1:0] a_v [4];
   logic signed [DW-1:0] b_v [4];

   logic                 s1_valid_ff;
   logic [1:0]           s1_act_ff;
   logic signed [PW-1:0] s1_pq_ff [4][4];
   logic signed [PW-1:0] s1_ww_ff, s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_xy_ff;
   logic signed [PW-1:0] s1_xz_ff, s1_yz_ff, s1_wx_ff, s1_wy_ff, s1_wz_ff;
   logic signed [DW-1:0] s1_b_ff [3];
   logic [3:0]           s1_neg_ff;
   logic [DW-1:0]        s1_mag_ff [4];
   logic                 s1_zero_ff;

   always_comb begin
      a_v[0] = req_data.a_w;
      a_v[1] = req_data.a_x;
      a_v[2] = req_data.a_y;
      a_v[3] = req_data.a_z;
      b_v[0] = req_data.b_w;
      b_v[1] = req_data.b_x;
      b_v[2] = req_data.b_y;
      b_v[3] = req_data.b_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_act_ff <= req_data.action;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_pq_ff[i][j] <= PW'(a_v[i]) * PW'(b_v[j]);
         end
         s1_neg_ff[i] <= a_v[i][DW-1];
         s1_mag_ff[i] <= a_v[i][DW-1] ? DW'(-a_v[i]) : DW'(a_v[i]);
      end
      for (int j = 0; j < 3; j++) begin
         s1_b_ff[j] <= b_v[j+1];
      end
      s1_ww_ff   <= PW'(a_v[0]) * PW'(a_v[0]);
      s1_xx_ff   <= PW'(a_v[1]) * PW'(a_v[1]);
      s1_yy_ff   <= PW'(a_v[2]) * PW'(a_v[2]);
      s1_zz_ff   <= PW'(a_v[3]) * PW'(a_v[3]);
      s1_xy_ff   <= PW'(a_v[1]) * PW'(a_v[2]);
      s1_xz_ff   <= PW'(a_v[1]) * PW'(a_v[3]);
      s1_yz_ff   <= PW'(a_v[2]) * PW'(a_v[3]);
      s1_wx_ff   <= PW'(a_v[0]) * PW'(a_v[1]);
      s1_wy_ff   <= PW'(a_v[0]) * PW'(a_v[2]);
      s1_wz_ff   <= PW'(a_v[0]) * PW'(a_v[3]);
      s1_zero_ff <= (req_data.a_w == '0) && (req_data.a_x == '0) &&
                    (req_data.a_y == '0) && (req_data.a_z == '0);
   end

   // stage 2: product sums, rotation matrix, squared length
   logic signed [XW-1:0] psum [4];
   logic signed [MW-1:0] mfull [9];
   logic signed [MW-1:0] mrnd;
   logic signed [MW-1:0] xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2, one_m;
   logic signed [MRW-1:0] m_in [9];
   logic [DSW-1:0]       d_in;
   meta_type             s2_meta_in;

   always_comb begin
      psum[0] = XW'(s1_pq_ff[0][0]) - XW'(s1_pq_ff[1][1])
              - XW'(s1_pq_ff[2][2]) - XW'(s1_pq_ff[3][3]);
      psum[1] = XW'(s1_pq_ff[0][1]) + XW'(s1_pq_ff[1][0])
              + XW'(s1_pq_ff[2][3]) - XW'(s1_pq_ff[3][2]);
      psum[2] = XW'(s1_pq_ff[0][2]) + XW'(s1_pq_ff[2][0])
              + XW'(s1_pq_ff[3][1]) - XW'(s1_pq_ff[1][3]);
      psum[3] = XW'(s1_pq_ff[0][3]) + XW'(s1_pq_ff[3][0])
              + XW'(s1_pq_ff[1][2]) - XW'(s1_pq_ff[2][1]);

      one_m = MW'(1) <<< (2 * F);
      xx2   = MW'(s1_xx_ff) <<< 1;
      yy2   = MW'(s1_yy_ff) <<< 1;
      zz2   = MW'(s1_zz_ff) <<< 1;
      xy2   = MW'(s1_xy_ff) <<< 1;
      xz2   = MW'(s1_xz_ff) <<< 1;
      yz2   = MW'(s1_yz_ff) <<< 1;
      wx2   = MW'(s1_wx_ff) <<< 1;
      wy2   = MW'(s1_wy_ff) <<< 1;
      wz2   = MW'(s1_wz_ff) <<< 1;
      mfull[0] = one_m - (yy2 + zz2);
      mfull[1] = xy2 - wz2;
      mfull[2] = xz2 + wy2;
      mfull[3] = xy2 + wz2;
      mfull[4] = one_m - (xx2 + zz2);
      mfull[5] = yz2 - wx2;
      mfull[6] = xz2 - wy2;
      mfull[7] = yz2 + wx2;
      mfull[8] = one_m - (xx2 + yy2);
      mrnd = '0;
      for (int k = 0; k < 9; k++) begin
         mrnd    = (mfull[k] + (MW'(1) <<< (F - 1))) >>> F;
         m_in[k] = mrnd[MRW-1:0];
      end

      d_in = DSW'($unsigned(s1_ww_ff)) + DSW'($unsigned(s1_xx_ff))
           + DSW'($unsigned(s1_yy_ff)) + DSW'($unsigned(s1_zz_ff));

      s2_meta_in.act  = s1_act_ff;
      s2_meta_in.zero = s1_zero_ff;
      s2_meta_in.neg  = s1_neg_ff;
      if (s1_act_ff == qau_pkg::ACT_PRODUCT) begin
         s2_meta_in.r_w = sat_x(rnd_x(psum[0]));
         s2_meta_in.r_x = sat_x(rnd_x(psum[1]));
         s2_meta_in.r_y = sat_x(rnd_x(psum[2]));
         s2_meta_in.r_z = sat_x(rnd_x(psum[3]));
      end else begin
         s2_meta_in.r_w = '0;
         s2_meta_in.r_x = '0;
         s2_meta_in.r_y = '0;
         s2_meta_in.r_z = '0;
      end
   end

   logic                  s2_valid_ff;
   meta_type              s2_meta_ff;
   logic signed [MRW-1:0] s2_m_ff [9];
   logic signed [DW-1:0]  s2_b_ff [3];
   logic [DSW-1:0]        s2_d_ff;
   logic [DW-1:0]         s2_mag_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_meta_ff <= s2_meta_in;
      for (int k = 0; k < 9; k++) begin
         s2_m_ff[k] <= m_in[k];
      end
      for (int j = 0; j < 3; j++) begin
         s2_b_ff[j] <= s1_b_ff[j];
      end
      for (int i = 0; i < 4; i++) begin
         s2_mag_ff[i] <= s1_mag_ff[i];
      end
      s2_d_ff <= d_in;
   end

   // stage 3: matrix times vector
   logic                 s3_valid_ff;
   meta_type             s3_meta_ff;
   logic signed [TW-1:0] s3_t_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_meta_ff <= s2_meta_ff;
      for (int k = 0; k < 9; k++) begin
         s3_t_ff[k] <= TW'(s2_m_ff[k]) * TW'(s2_b_ff[k % 3]);
      end
   end

   // stage 4: rotated vector
   logic signed [XW-1:0] rsum [3];
   meta_type             s4_meta_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsum[i] = XW'(s3_t_ff[3*i]) + XW'(s3_t_ff[3*i+1]) + XW'(s3_t_ff[3*i+2]);
      end
      s4_meta_in = s3_meta_ff;
      if (s3_meta_ff.act == qau_pkg::ACT_ROTATE) begin
         s4_meta_in.r_w = '0;
         s4_meta_in.r_x = sat_x(rnd_x(rsum[0]));
         s4_meta_in.r_y = sat_x(rnd_x(rsum[1]));
         s4_meta_in.r_z = sat_x(rnd_x(rsum[2]));
      end
   end

   logic     s4_valid_ff;
   meta_type s4_meta_ff;
   logic     dl_valid_ff [DLY];
   meta_type dl_meta_ff [DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         for (int k = 0; k < DLY; k++) begin
            dl_valid_ff[k] <= 1'b0;
         end
      end else begin
         s4_valid_ff    <= s3_valid_ff;
         dl_valid_ff[0] <= s4_valid_ff;
         for (int k = 1; k < DLY; k++) begin
            dl_valid_ff[k] <= dl_valid_ff[k-1];
         end
      end
      s4_meta_ff    <= s4_meta_in;
      dl_meta_ff[0] <= s4_meta_ff;
      for (int k = 1; k < DLY; k++) begin
         dl_meta_ff[k] <= dl_meta_ff[k-1];
      end
   end

   // length and per-component division
   logic [NW-1:0]     sq_n;
   logic [4*DW-1:0]   sq_side;
   logic [R-1:0]      sq_root;
   logic [4*DW-1:0]   sq_side_out;
   logic [NUM_W-1:0]  div_num [4];
   logic [QB-1:0]     div_q [4];

   assign sq_n    = NW'({s2_d_ff, {(2*NG){1'b0}}});
   assign sq_side = {s2_mag_ff[0], s2_mag_ff[1], s2_mag_ff[2], s2_mag_ff[3]};

   qau_isqrt #(
      .IN_W   (NW),
      .SIDE_W (4 * DW)
   ) u_isqrt (
      .clock    (clock),
      .in_n     (sq_n),
      .in_side  (sq_side),
      .out_root (sq_root),
      .out_side (sq_side_out)
   );

   for (genvar g = 0; g < 4; g++) begin : g_div
      assign div_num[g] = (NUM_W'(sq_side_out[(3-g)*DW +: DW]) << (F + NG))
                        + NUM_W'(sq_root >> 1);

      qau_div #(
         .NUM_W (NUM_W),
         .DEN_W (R),
         .QB    (QB)
      ) u_div (
         .clock  (clock),
         .in_num (div_num[g]),
         .in_den (sq_root),
         .out_q  (div_q[g])
      );
   end

   // final selection
   meta_type             fin;
   logic signed [XW-1:0] qs [4];
   logic signed [DW-1:0] qr [4];
   qau_pkg::rsp_type     rsp_in;

   always_comb begin
      fin = dl_meta_ff[DLY-1];
      for (int i = 0; i < 4; i++) begin
         qs[i] = XW'(div_q[i]);
         if (fin.neg[i]) begin
            qs[i] = -qs[i];
         end
         qr[i] = sat_x(qs[i]);
      end
      rsp_in.r_w         = fin.r_w;
      rsp_in.r_x         = fin.r_x;
      rsp_in.r_y         = fin.r_y;
      rsp_in.r_z         = fin.r_z;
      rsp_in.zero_length = 1'b0;
      if (fin.act == qau_pkg::ACT_NORMALIZE) begin
         if (fin.zero) begin
            rsp_in.r_w         = R_ONE;
            rsp_in.r_x         = '0;
            rsp_in.r_y         = '0;
            rsp_in.r_z         = '0;
            rsp_in.zero_length = 1'b1;
         end else begin
            rsp_in.r_w = qr[0];
            rsp_in.r_x = qr[1];
            rsp_in.r_y = qr[2];
            rsp_in.r_z = qr[3];
         end
      end
   end

   logic             rsp_valid_ff;
   qau_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dl_valid_ff[DLY-1];
      end
      rsp_data_ff <= rsp_in;
   end

   assign busy      = reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LAT) rsp_valid)
      else $error("accepted beat did not leave on time");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response beat without a matching request");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_length) |->
      (rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0))
      else $error("zero length beat is not the identity");
`endif

endmodule
